// ===== design/vfsg_pkg.sv =====
package vfsg_pkg;

  // Field widths of the request and segment words.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned TADDR_W = 12;
  localparam int unsigned TDATA_W = 12;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SCALE_W = 8;
  localparam int unsigned GRID_W  = 3;
  localparam int unsigned BASE_W  = 2;

  // Glyph index table geometry.
  localparam int unsigned INDEX_DEPTH = 256;

  // Parameter defaults for the top level.
  localparam int unsigned FONT_BYTES_DEF = 4096;
  localparam int unsigned MAX_POINTS_DEF = 64;

  // Request operations; the fourth code is ignored.
  typedef enum logic [OP_W-1:0] {
    OP_DRAW     = 2'd0,
    OP_INDEX_WR = 2'd1,
    OP_FONT_WR  = 2'd2
  } op_e;

  // Character codes that only move the pen.
  localparam logic [CODE_W-1:0] CODE_TAB = 8'd9;
  localparam logic [CODE_W-1:0] CODE_LF  = 8'd10;

  // Pen moves in font grid units.
  localparam int unsigned ADV_GLYPH = 8;
  localparam int unsigned ADV_TAB   = 16;
  localparam int unsigned DROP_LF   = 6;

  // Bit positions in a point byte.
  localparam int unsigned PT_GLYPH_END = 7;
  localparam int unsigned PT_SEG_END   = 6;

endpackage

// ===== design/vfsg_if.sv =====
// Request word channel: draw, index write or font byte write.
interface vfsg_req_if import vfsg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [CODE_W-1:0]         char_code;
  logic [TADDR_W-1:0]        table_address;
  logic [TDATA_W-1:0]        table_data;
  logic                      new_text;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;

  modport source (
    output valid, operation, char_code, table_address, table_data,
           new_text, start_x, start_y,
    input  ready
  );
  modport sink (
    input  valid, operation, char_code, table_address, table_data,
           new_text, start_x, start_y,
    output ready
  );
endinterface

// Segment word channel.
interface vfsg_seg_if import vfsg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] seg_x1;
  logic signed [COORD_W-1:0] seg_y1;
  logic signed [COORD_W-1:0] seg_x2;
  logic signed [COORD_W-1:0] seg_y2;
  logic                      last_segment;

  modport source (
    output valid, seg_x1, seg_y1, seg_x2, seg_y2, last_segment,
    input  ready
  );
  modport sink (
    input  valid, seg_x1, seg_y1, seg_x2, seg_y2, last_segment,
    output ready
  );
endinterface

// ===== design/vfsg_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
// The read data holds its value in cycles without a read.
module vfsg_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/vfsg_place.sv =====
// Places one font grid coordinate: origin + (grid + base) * scale, wrapped.
module vfsg_place import vfsg_pkg::*; (
  input  logic [COORD_W-1:0] origin_i,
  input  logic [GRID_W-1:0]  grid_i,
  input  logic [BASE_W-1:0]  base_i,
  input  logic [SCALE_W-1:0] scale_i,
  output logic [COORD_W-1:0] coord_o
);

  localparam int unsigned SUM_W  = GRID_W + 1;
  localparam int unsigned PROD_W = SUM_W + SCALE_W;

  logic [SUM_W-1:0]  units;
  logic [PROD_W-1:0] offset;

  // Grid units times scale, then added to the pen.
  assign units   = SUM_W'(grid_i) + SUM_W'(base_i);
  assign offset  = PROD_W'(units) * PROD_W'(scale_i);
  assign coord_o = origin_i + COORD_W'(offset);

endmodule

// ===== design/vector_font_stroke_generator.sv =====
// Vector font stroke generator. Each draw word names one character; the block
// looks up its glyph start address in the glyph index table and then walks the
// glyph's point bytes in the font memory, sending line and dot segment words,
// scaled by the scale register and offset by the pen. Tab and linefeed
// words move the pen only, and a character whose index entry is zero only
// advances it. Index and font bytes are loaded with write words and must be
// written before they are used. The font memory is read once per point byte;
// a segment-ending point that follows a point which draws a line to it yields
// two segment words, the line and then a dot. A segment word that is not yet
// taken holds the walk. The block takes one character at a time.
module vector_font_stroke_generator import vfsg_pkg::*; #(
  parameter int unsigned FONT_BYTES = FONT_BYTES_DEF,
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SCALE_W-1:0] cfg_wdata_i,
  vfsg_req_if.sink           in_i,
  vfsg_seg_if.source         out_o
);

  localparam int unsigned AW = $clog2(FONT_BYTES);
  localparam int unsigned EW = (AW > TADDR_W) ? AW : TADDR_W;
  localparam int unsigned KW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW = $clog2(INDEX_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_HEAD   = 5'b00100,
    ST_POINT  = 5'b01000,
    ST_DOT    = 5'b10000
  } state_e;

  state_e             st_q, st_d;
  logic [SCALE_W-1:0] scale_q;
  logic [COORD_W-1:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d, line_x_q, line_x_d;
  logic [AW-1:0]      addr_q, addr_d, addr_next;
  logic [KW-1:0]      k_q, k_d;
  logic [BASE_W-1:0]  xbase_q, xbase_d, ybase_q, ybase_d;
  logic               pend_q, pend_d;
  logic [COORD_W-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;

  logic               out_valid_q;
  logic [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic               last_q;

  logic               accept, out_free;
  logic               idx_we, idx_re, font_we, font_re;
  logic [TDATA_W-1:0] idx_rdata;
  logic [BYTE_W-1:0]  pt;
  logic [AW-1:0]      font_raddr;
  logic [EW-1:0]      idx_ext, waddr_ext;
  logic               pt_last, pt_dot;
  logic [COORD_W-1:0] px, py;
  logic [COORD_W-1:0] base_x, base_y, base_line;
  logic [COORD_W-1:0] adv_glyph, adv_tab, drop_lf;
  logic               emit, emit_last;
  logic [COORD_W-1:0] emit_x1, emit_y1, emit_x2, emit_y2;

  // Handshake qualifiers.
  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (st_q == ST_IDLE);
  assign out_free  = !out_valid_q || out_o.ready;

  // Table writes come straight from accepted write words.
  assign idx_we    = accept && (op_e'(in_i.operation) == OP_INDEX_WR);
  assign font_we   = accept && (op_e'(in_i.operation) == OP_FONT_WR);
  assign waddr_ext = EW'(in_i.table_address);
  assign idx_ext   = EW'(idx_rdata);

  vfsg_ram #(
    .DEPTH (INDEX_DEPTH),
    .WIDTH (TDATA_W)
  ) u_index (
    .clk_i   (clk_i),
    .we_i    (idx_we),
    .waddr_i (in_i.char_code[IW-1:0]),
    .wdata_i (in_i.table_data),
    .re_i    (idx_re),
    .raddr_i (in_i.char_code[IW-1:0]),
    .rdata_o (idx_rdata)
  );

  vfsg_ram #(
    .DEPTH (FONT_BYTES),
    .WIDTH (BYTE_W)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (waddr_ext[AW-1:0]),
    .wdata_i (in_i.table_data[BYTE_W-1:0]),
    .re_i    (font_re),
    .raddr_i (font_raddr),
    .rdata_o (pt)
  );

  // Decode and place the point byte currently on the font read port.
  assign pt_last = pt[PT_GLYPH_END] || (k_q == KW'(MAX_POINTS));
  assign pt_dot  = pt_last || pt[PT_SEG_END];

  vfsg_place u_place_x (
    .origin_i (pen_x_q),
    .grid_i   (pt[5:3]),
    .base_i   (xbase_q),
    .scale_i  (scale_q),
    .coord_o  (px)
  );

  vfsg_place u_place_y (
    .origin_i (pen_y_q),
    .grid_i   (pt[2:0]),
    .base_i   (ybase_q),
    .scale_i  (scale_q),
    .coord_o  (py)
  );

  // Pen moves scaled to pixels.
  assign adv_glyph = COORD_W'(scale_q) * COORD_W'(ADV_GLYPH);
  assign adv_tab   = COORD_W'(scale_q) * COORD_W'(ADV_TAB);
  assign drop_lf   = COORD_W'(scale_q) * COORD_W'(DROP_LF);

  // Pen as seen by a draw word, after an optional new text start.
  assign base_x    = in_i.new_text ? COORD_W'(in_i.start_x) : pen_x_q;
  assign base_y    = in_i.new_text ? COORD_W'(in_i.start_y) : pen_y_q;
  assign base_line = in_i.new_text ? COORD_W'(in_i.start_x) : line_x_q;

  assign addr_next = addr_q + AW'(1);

  // Sequencer: index lookup, glyph head, then one point byte per read.
  always_comb begin
    st_d       = st_q;
    pen_x_d    = pen_x_q;
    pen_y_d    = pen_y_q;
    line_x_d   = line_x_q;
    addr_d     = addr_q;
    k_d        = k_q;
    xbase_d    = xbase_q;
    ybase_d    = ybase_q;
    pend_d     = pend_q;
    pend_x_d   = pend_x_q;
    pend_y_d   = pend_y_q;
    idx_re     = 1'b0;
    font_re    = 1'b0;
    font_raddr = addr_next;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_x1    = px;
    emit_y1    = py;
    emit_x2    = px;
    emit_y2    = py;
    case (st_q)
      ST_IDLE: begin
        if (accept && (op_e'(in_i.operation) == OP_DRAW)) begin
          pen_x_d  = base_x;
          pen_y_d  = base_y;
          line_x_d = base_line;
          if (in_i.char_code == CODE_TAB) begin
            pen_x_d = base_x + adv_tab;
          end else if (in_i.char_code == CODE_LF) begin
            pen_x_d = base_line;
            pen_y_d = base_y + drop_lf;
          end else begin
            idx_re = 1'b1;
            st_d   = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (idx_rdata == '0) begin
          pen_x_d = pen_x_q + adv_glyph;
          st_d    = ST_IDLE;
        end else begin
          font_re    = 1'b1;
          font_raddr = idx_ext[AW-1:0];
          addr_d     = idx_ext[AW-1:0];
          st_d       = ST_HEAD;
        end
      end
      ST_HEAD: begin
        xbase_d = pt[3:2];
        ybase_d = pt[1:0];
        font_re = 1'b1;
        addr_d  = addr_next;
        k_d     = KW'(1);
        pend_d  = 1'b0;
        st_d    = ST_POINT;
      end
      ST_POINT: begin
        if (pend_q) begin
          // Close the line that the previous point opened.
          if (out_free) begin
            emit    = 1'b1;
            emit_x1 = pend_x_q;
            emit_y1 = pend_y_q;
            if (pt_dot) begin
              pend_d = 1'b0;
              st_d   = ST_DOT;
            end else begin
              pend_x_d = px;
              pend_y_d = py;
              font_re  = 1'b1;
              addr_d   = addr_next;
              k_d      = k_q + KW'(1);
            end
          end
        end else if (pt_dot) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_last = pt_last;
            if (pt_last) begin
              pen_x_d = pen_x_q + adv_glyph;
              st_d    = ST_IDLE;
            end else begin
              font_re = 1'b1;
              addr_d  = addr_next;
              k_d     = k_q + KW'(1);
            end
          end
        end else begin
          // This point opens a line to the next one.
          pend_d   = 1'b1;
          pend_x_d = px;
          pend_y_d = py;
          font_re  = 1'b1;
          addr_d   = addr_next;
          k_d      = k_q + KW'(1);
        end
      end
      ST_DOT: begin
        // The same point byte still sits on the read port.
        if (out_free) begin
          emit      = 1'b1;
          emit_last = pt_last;
          if (pt_last) begin
            pen_x_d = pen_x_q + adv_glyph;
            st_d    = ST_IDLE;
          end else begin
            font_re = 1'b1;
            addr_d  = addr_next;
            k_d     = k_q + KW'(1);
            st_d    = ST_POINT;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control and pen state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      scale_q     <= SCALE_W'(1);
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      line_x_q    <= '0;
      pend_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      line_x_q    <= line_x_d;
      pend_q      <= pend_d;
      k_q         <= k_d;
      out_valid_q <= emit || (out_valid_q && !out_o.ready);
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  // Walk registers and the segment word register.
  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    xbase_q  <= xbase_d;
    ybase_q  <= ybase_d;
    pend_x_q <= pend_x_d;
    pend_y_q <= pend_y_d;
    if (emit) begin
      x1_q   <= emit_x1;
      y1_q   <= emit_y1;
      x2_q   <= emit_x2;
      y2_q   <= emit_y2;
      last_q <= emit_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.seg_x1       = x1_q;
  assign out_o.seg_y1       = y1_q;
  assign out_o.seg_x2       = x2_q;
  assign out_o.seg_y2       = y2_q;
  assign out_o.last_segment = last_q;

  // The point counter stays within the glyph limit while walking points.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_POINT || st_q == ST_DOT) |-> (k_q != '0 && k_q <= KW'(MAX_POINTS)))
    else $error("point counter out of range");

  // A new segment word never overwrites one that was not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("segment word overwritten");

  // The final segment of a glyph returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (st_q == ST_IDLE))
    else $error("glyph did not finish after its last segment");

  // A dot is never emitted with an open line still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DOT) |-> !pend_q)
    else $error("open line pending during dot");

endmodule
